>>> rtl/core/cded_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cded_pkg
// Shared types, constants and helpers of the colour-distance edge detector.
// ----------------------------------------------------------------------------
package cded_pkg;

   // pixel and result field widths
   localparam int COMP_W      = 8;
   localparam int SQ_W        = 2 * COMP_W;
   localparam int SUM_W       = SQ_W + 2;

   // configuration register widths and reset values
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int THR_REG_W    = 9;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 2;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int THR_RESET    = 20;

   // geometry limits
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int ROW_W         = 12;

   // result codes
   localparam logic [COMP_W-1:0] PIX_EDGE    = 8'd0;
   localparam logic [COMP_W-1:0] PIX_NO_EDGE = 8'd255;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   // per-item control travelling down the pipeline
   typedef struct packed {
      logic has_up;     // result for the pixel above is due
      logic has_own;    // result for this pixel is due (last row)
      logic x_nz;       // column is not the first one
      logic frame_end;  // pixel is in the last column
   } ctrl_type;

   typedef struct packed {
      logic [COMP_W-1:0] edge_pixel;
      logic              frame_end;
   } result_type;

   // squared difference of two colour components
   function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                               input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cded_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cded_req_if / cded_rsp_if
// Valid/ready channels carrying input pixels and edge results.
// ----------------------------------------------------------------------------
interface cded_req_if import cded_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] red;
   logic [COMP_W-1:0] green;
   logic [COMP_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface cded_rsp_if import cded_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] edge_pixel;
   logic              frame_end;

   modport source (output valid, output edge_pixel, output frame_end, input ready);
   modport sink   (input valid, input edge_pixel, input frame_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/color_distance_edge_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_distance_edge_detector
// Raster-order RGB edge detector with a one-row line store in block memory.
// ----------------------------------------------------------------------------
// An accepted pixel passes through stage 1, stage 2 and then the result
// buffer before its first result is offered.
// Throughput: one pixel per cycle while results are taken; last-row pixels
// below the first row give two results each, so there the single result
// port sets the pace. Reset clears position counters, neighbour registers,
// stage valid flags and the result count; the line store is not cleared.
// ----------------------------------------------------------------------------
module color_distance_edge_detector import cded_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire                     clock,
   input  wire                     reset,
   cded_req_if.sink                req_chan,
   cded_rsp_if.source              rsp_chan,
   input  wire                     csr_we,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
   localparam int WEXT_W  = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;
   localparam int THRSQ_W = 2 * THR_REG_W;

   // configuration registers
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [THR_REG_W-1:0]    thr_ff;
   logic [THRSQ_W-1:0]      thr_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(WIDTH_RESET);
         height_ff <= HEIGHT_REG_W'(HEIGHT_RESET);
         thr_ff    <= THR_REG_W'(THR_RESET);
         thr_sq_ff <= THRSQ_W'(THR_RESET * THR_RESET);
      end else begin
         thr_sq_ff <= THRSQ_W'(thr_ff) * THRSQ_W'(thr_ff);
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_IMAGE_WIDTH:    width_ff  <= WIDTH_REG_W'(csr_wdata);
               CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
               CSR_EDGE_THRESHOLD: thr_ff    <= THR_REG_W'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   // clamped geometry, as last column and last row
   logic [WEXT_W-1:0] width_ext;
   logic [COL_W-1:0]  w_last;
   logic [ROW_W-1:0]  h_last;

   always_comb begin
      width_ext = WEXT_W'(width_ff);
      if (width_ext == '0)
         w_last = '0;
      else if (width_ext > WEXT_W'(MAX_WIDTH))
         w_last = COL_W'(MAX_WIDTH - 1);
      else
         w_last = COL_W'(width_ext - WEXT_W'(1));

      if (height_ff == '0)
         h_last = '0;
      else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT))
         h_last = ROW_W'(MAX_HEIGHT - 1);
      else
         h_last = ROW_W'(height_ff - HEIGHT_REG_W'(1));
   end

   // pipeline control
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       adv;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       s1_valid_ff, s2_valid_ff;

   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;
   assign adv            = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_chan.ready);
   assign req_chan.ready = adv;
   assign req_xfer       = req_chan.valid && adv;

   // position of the incoming pixel
   logic [COL_W-1:0] col_ff, col_in, x_cur;
   logic [ROW_W-1:0] row_ff, row_in, y_cur;
   logic             wrap;
   pixel_type        px_cur;
   ctrl_type         ctrl_cur;

   always_comb begin
      wrap   = (col_ff > w_last) || (row_ff > h_last);
      x_cur  = wrap ? '0 : col_ff;
      y_cur  = wrap ? '0 : row_ff;
      px_cur = '{red: req_chan.red, green: req_chan.green, blue: req_chan.blue};

      ctrl_cur.has_up    = (y_cur != '0);
      ctrl_cur.has_own   = (y_cur == h_last);
      ctrl_cur.x_nz      = (x_cur != '0);
      ctrl_cur.frame_end = (x_cur == w_last);

      col_in = col_ff;
      row_in = row_ff;
      if (req_xfer) begin
         if (x_cur == w_last) begin
            col_in = '0;
            row_in = (y_cur == h_last) ? '0 : y_cur + ROW_W'(1);
         end else begin
            col_in = x_cur + COL_W'(1);
            row_in = y_cur;
         end
      end
   end

   // line store: read-first, read and write at the same column on a transfer
   pixel_type row_mem [MAX_WIDTH];
   pixel_type above_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         above_ff     <= row_mem[x_cur];
         row_mem[x_cur] <= px_cur;
      end
   end

   // stage 1 registers and neighbour state
   pixel_type s1_px_ff, s1_left_ff, left_ff, above_left_ff;
   ctrl_type  s1_ctrl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (req_xfer)
            left_ff <= px_cur;
         if (adv) begin
            s1_valid_ff <= req_xfer;
            if (s1_valid_ff)
               above_left_ff <= above_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_px_ff   <= px_cur;
         s1_left_ff <= left_ff;
         s1_ctrl_ff <= ctrl_cur;
      end
   end

   // stage 2: squared component differences
   logic [SQ_W-1:0] sq_ul_ff [3];
   logic [SQ_W-1:0] sq_up_ff [3];
   logic [SQ_W-1:0] sq_own_ff[3];
   ctrl_type        s2_ctrl_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else if (adv)
         s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         sq_ul_ff[0]  <= sq_diff(above_ff.red,   above_left_ff.red);
         sq_ul_ff[1]  <= sq_diff(above_ff.green, above_left_ff.green);
         sq_ul_ff[2]  <= sq_diff(above_ff.blue,  above_left_ff.blue);
         sq_up_ff[0]  <= sq_diff(above_ff.red,   s1_px_ff.red);
         sq_up_ff[1]  <= sq_diff(above_ff.green, s1_px_ff.green);
         sq_up_ff[2]  <= sq_diff(above_ff.blue,  s1_px_ff.blue);
         sq_own_ff[0] <= sq_diff(s1_px_ff.red,   s1_left_ff.red);
         sq_own_ff[1] <= sq_diff(s1_px_ff.green, s1_left_ff.green);
         sq_own_ff[2] <= sq_diff(s1_px_ff.blue,  s1_left_ff.blue);
         s2_ctrl_ff   <= s1_ctrl_ff;
      end
   end

   // distance sums against squared threshold
   logic [SUM_W-1:0] sum_ul, sum_up, sum_own;
   logic             up_edge, own_edge;
   result_type       res_up, res_own;

   always_comb begin
      sum_ul  = SUM_W'(sq_ul_ff[0])  + SUM_W'(sq_ul_ff[1])  + SUM_W'(sq_ul_ff[2]);
      sum_up  = SUM_W'(sq_up_ff[0])  + SUM_W'(sq_up_ff[1])  + SUM_W'(sq_up_ff[2]);
      sum_own = SUM_W'(sq_own_ff[0]) + SUM_W'(sq_own_ff[1]) + SUM_W'(sq_own_ff[2]);
      up_edge  = s2_ctrl_ff.x_nz &&
                 ((SUM_W'(sum_ul) > SUM_W'(thr_sq_ff)) || (sum_up > SUM_W'(thr_sq_ff)));
      own_edge = s2_ctrl_ff.x_nz && (sum_own > SUM_W'(thr_sq_ff));
      res_up   = '{edge_pixel: up_edge ? PIX_EDGE : PIX_NO_EDGE, frame_end: 1'b0};
      res_own  = '{edge_pixel: own_edge ? PIX_EDGE : PIX_NO_EDGE,
                   frame_end: s2_ctrl_ff.frame_end};
   end

   // two-entry result buffer
   result_type slot_ff [2];
   result_type slot_in [2];

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      out_cnt_in = out_cnt_ff;
      if (rsp_xfer) begin
         slot_in[0] = slot_ff[1];
         out_cnt_in = out_cnt_ff - 2'd1;
      end
      if (adv && s2_valid_ff) begin
         slot_in[0] = s2_ctrl_ff.has_up ? res_up : res_own;
         slot_in[1] = res_own;
         out_cnt_in = 2'(s2_ctrl_ff.has_up) + 2'(s2_ctrl_ff.has_own);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_cnt_ff <= 2'd0;
      else
         out_cnt_ff <= out_cnt_in;
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_chan.valid      = (out_cnt_ff != 2'd0);
   assign rsp_chan.edge_pixel = slot_ff[0].edge_pixel;
   assign rsp_chan.frame_end  = slot_ff[0].frame_end;

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted pixel did not enter stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !adv) |=> (s2_valid_ff && $stable(s2_ctrl_ff)))
      else $error("stage 2 lost its item during a stall");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff == 2'd2) |-> !req_xfer)
      else $error("pixel accepted while result buffer full");

endmodule

`default_nettype wire

>>> dv/cded_edge_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cded_edge_check
// Watches the pixel, result and register ports of the edge detector, keeps
// its own copy of geometry, line store and neighbour pixels, works out the
// edge results each accepted pixel is due to produce and compares every
// result transfer against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module cded_edge_check import cded_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   cded_req_if                   req,
   cded_rsp_if                   rsp,
   input  wire                   csr_we,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    due_count,
   output int                    checked_count,
   output int                    edge_count,
   output int                    frame_count
);

   localparam int SHOW_LIMIT = 20;

   // register copies
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [THR_REG_W-1:0]    thr_reg;

   // scan position, previous row and neighbours
   pixel_type   line_mem [DEF_MAX_WIDTH];
   int unsigned col_pos;
   int unsigned row_pos;
   pixel_type   left_px;
   pixel_type   above_left_px;

   result_type  due_results [$];
   int          shown;

   // squared difference of one colour component
   function automatic int unsigned comp_sq(input logic [COMP_W-1:0] a,
                                           input logic [COMP_W-1:0] b);
      int unsigned d;
      d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
      return d * d;
   endfunction

   // squared colour distance above the squared threshold
   function automatic bit far_apart(input pixel_type a, input pixel_type b);
      int unsigned dist_sq;
      int unsigned thr_sq;
      dist_sq = comp_sq(a.red, b.red) + comp_sq(a.green, b.green) +
                comp_sq(a.blue, b.blue);
      thr_sq  = thr_reg;
      thr_sq  = thr_sq * thr_sq;
      return dist_sq > thr_sq;
   endfunction

   // queue the results a pixel releases and step the scan position
   function automatic void predict_edges(input pixel_type px);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      pixel_type   above;
      result_type  r;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      // position outside the geometry starts a new frame
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      above = line_mem[x];
      // the pixel above is now complete
      if (y > 0) begin
         r.edge_pixel = (x != 0 && (far_apart(above, above_left_px) ||
                                    far_apart(above, px))) ? PIX_EDGE : PIX_NO_EDGE;
         r.frame_end  = 1'b0;
         due_results.push_back(r);
      end
      // last row: left neighbour only
      if (y == h - 1) begin
         r.edge_pixel = (x != 0 && far_apart(px, left_px)) ? PIX_EDGE : PIX_NO_EDGE;
         r.frame_end  = (x == w - 1);
         due_results.push_back(r);
      end
      above_left_px = above;
      line_mem[x]   = px;
      left_px       = px;
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (shown < SHOW_LIMIT)
         $display("%0t ns: result %0d: %s got %0d, expected %0d",
                  $time, checked_count, what, got, want);
      shown++;
      fail_count++;
   endtask

   // compare one result transfer with the oldest due result
   task automatic check_result();
      result_type r;
      if (due_results.size() == 0) begin
         report_mismatch("unexpected transfer, edge_pixel", rsp.edge_pixel, -1);
      end else begin
         r = due_results.pop_front();
         if (rsp.edge_pixel !== r.edge_pixel)
            report_mismatch("edge_pixel", rsp.edge_pixel, r.edge_pixel);
         if (rsp.frame_end !== r.frame_end)
            report_mismatch("frame_end", rsp.frame_end, r.frame_end);
      end
      if (rsp.edge_pixel == PIX_EDGE) edge_count++;
      if (rsp.frame_end) frame_count++;
      checked_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg     = WIDTH_RESET;
         height_reg    = HEIGHT_RESET;
         thr_reg       = THR_RESET;
         col_pos       = 0;
         row_pos       = 0;
         left_px       = '0;
         above_left_px = '0;
         due_results.delete();
         fail_count    = 0;
         checked_count = 0;
         edge_count    = 0;
         frame_count   = 0;
         shown         = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_IMAGE_WIDTH:    width_reg  = csr_wdata[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT:   height_reg = csr_wdata[HEIGHT_REG_W-1:0];
               CSR_EDGE_THRESHOLD: thr_reg    = csr_wdata[THR_REG_W-1:0];
               default: ;
            endcase
         end
         // pixel transfer
         if (req.valid && req.ready)
            predict_edges({req.red, req.green, req.blue});
         // result transfer
         if (rsp.valid && rsp.ready)
            check_result();
      end
      due_count = due_results.size();
   end

endmodule

>>> dv/tb_color_distance_edge_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_distance_edge_detector
// Streams RGB frames into the edge detector: a directed set of extreme
// pixels and geometry corner cases, then random frames of small random
// geometry and threshold, under changing sender and receiver idling and one
// long receiver hold-off. Results are checked by cded_edge_check.
// ----------------------------------------------------------------------------
module tb_color_distance_edge_detector;
   import cded_pkg::*;

   localparam int TOTAL_PIXELS   = 650;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 16;
   localparam int LONG_STALL     = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cded_req_if pix_chan ();
   cded_rsp_if edge_chan ();

   int fail_count;
   int due_count;
   int checked_count;
   int edge_count;
   int frame_count;

   int   tx_idle_pct = 35;
   int   rx_idle_pct = 78;
   logic pressure_on = 1'b0;
   logic stall_taken;
   int   stall_left;
   int   quiet_cycles;
   int   pixels_sent = 0;
   int   geometry_count = 0;

   color_distance_edge_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (pix_chan),
      .rsp_chan  (edge_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cded_edge_check edge_check (
      .clock         (clock),
      .reset         (reset),
      .req           (pix_chan),
      .rsp           (edge_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .due_count     (due_count),
      .checked_count (checked_count),
      .edge_count    (edge_count),
      .frame_count   (frame_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result receiver: random stalls, one long hold-off when pressure is asked
   always @(posedge clock) begin
      if (reset) begin
         edge_chan.ready <= 1'b0;
         stall_left      <= 0;
         stall_taken     <= 1'b0;
      end else if (pressure_on && !stall_taken) begin
         edge_chan.ready <= 1'b0;
         stall_left      <= LONG_STALL;
         stall_taken     <= 1'b1;
      end else if (stall_left != 0) begin
         edge_chan.ready <= 1'b0;
         stall_left      <= stall_left - 1;
      end else begin
         edge_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (pix_chan.valid && pix_chan.ready) ||
          (edge_chan.valid && edge_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, due_count);
            $display("FAIL");
            $finish;
         end
      end
   end

   // offer one pixel, with random gaps before it, until transferred
   task automatic send_pixel(input pixel_type p);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         pix_chan.valid <= 1'b0;
         @(posedge clock);
      end
      pix_chan.valid <= 1'b1;
      {pix_chan.red, pix_chan.green, pix_chan.blue} <= p;
      do @(posedge clock); while (!pix_chan.ready);
      pixels_sent++;
   endtask

   // stop offering, wait for all due results and let the pipeline empty
   task automatic settle();
      pix_chan.valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h, input int thr);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_EDGE_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_we    <= 1'b0;
      geometry_count++;
   endtask

   // colour component near an anchor value
   function automatic logic [COMP_W-1:0] shade(input logic [COMP_W-1:0] c,
                                               input int spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return COMP_W'(v);
   endfunction

   // frame content: mostly shades of a drifting anchor, some noise pixels
   task automatic send_frame(input int n);
      pixel_type anchor;
      pixel_type p;
      int        spread;
      anchor = pixel_type'($urandom_range(0, 24'hFFFFFF));
      spread = $urandom_range(0, 40);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            anchor = pixel_type'($urandom_range(0, 24'hFFFFFF));
         if ($urandom_range(0, 99) < 25) begin
            p = pixel_type'($urandom_range(0, 24'hFFFFFF));
         end else begin
            p.red   = shade(anchor.red, spread);
            p.green = shade(anchor.green, spread);
            p.blue  = shade(anchor.blue, spread);
         end
         send_pixel(p);
      end
   endtask

   initial begin
      int w_pick;
      int h_pick;
      int thr_pick;
      int mode;
      pix_chan.valid  <= 1'b0;
      pix_chan.red    <= '0;
      pix_chan.green  <= '0;
      pix_chan.blue   <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_IMAGE_WIDTH;
      csr_wdata       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // equal, opposite and single-component pixels with a zero threshold
      set_geometry(3, 3, 0);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFF0000);
      send_pixel(24'h00FF00);
      send_pixel(24'h0000FF);
      send_pixel(24'h0000FF);
      send_pixel(24'h0000FF);
      send_pixel(24'h123456);
      settle();

      // single-row frame, largest threshold against the largest distance
      set_geometry(2, 1, 511);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      settle();

      // zero geometry acts as a one-pixel frame
      set_geometry(0, 0, 1);
      send_pixel(24'hA5A5A5);
      send_pixel(24'h5A5A5A);
      settle();

      // oversized geometry clamps; frame left open at column 2
      set_geometry(2047, 8191, THR_RESET);
      send_pixel(24'h800000);
      send_pixel(24'h7F0000);
      settle();

      // width below the open column restarts the frame
      set_geometry(2, 2, 10);
      send_pixel(24'h0A0A0A);
      send_pixel(24'h0A0A14);
      settle();
      // width shrinks but still covers the open column: frame carries on
      set_geometry(1, 2, 10);
      send_pixel(24'hF0F0F0);
      settle();

      // height below the open row restarts the frame
      set_geometry(1, 3, 10);
      send_pixel(24'h202020);
      send_pixel(24'hE0E0E0);
      settle();
      set_geometry(1, 2, 10);
      send_pixel(24'h00FFFF);
      send_pixel(24'hFF00FF);
      settle();

      // random frames under three idling regimes
      mode = 0;
      while (pixels_sent < TOTAL_PIXELS) begin
         if (mode == 0 && pixels_sent >= 230) begin
            mode = 1;
            tx_idle_pct <= 78;
            rx_idle_pct <= 35;
         end else if (mode == 1 && pixels_sent >= 440) begin
            mode = 2;
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
            // long receiver hold-off while a full frame streams in
            set_geometry(16, 8, 30);
            pressure_on <= 1'b1;
            send_frame(16 * 8);
            settle();
         end
         w_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48)
                                              : $urandom_range(1, 10);
         h_pick = $urandom_range(0, 5);
         case ($urandom_range(0, 5))
            0:       thr_pick = 0;
            1:       thr_pick = 511;
            2:       thr_pick = $urandom_range(0, 511);
            default: thr_pick = $urandom_range(0, 60);
         endcase
         set_geometry(w_pick, h_pick, thr_pick);
         send_frame(w_pick * ((h_pick == 0) ? 1 : h_pick));
         settle();
      end

      pix_chan.valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d pixels over %0d geometries; checked %0d results",
               pixels_sent, geometry_count, checked_count);
      $display("with %0d edges and %0d frame ends", edge_count, frame_count);
      if (fail_count == 0 && due_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", fail_count, due_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> color_distance_edge_detector.f
rtl/core/cded_pkg.sv
rtl/core/cded_if.sv
rtl/core/color_distance_edge_detector.sv
dv/cded_edge_check.sv
dv/tb_color_distance_edge_detector.sv
